@@ design/assert_macros.svh @@
// Assertion macros used by ffpe_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ design/ffpe_pkg.sv @@
package ffpe_pkg;

    localparam int PAGE_FIELD_W = 40;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic [PAGE_FIELD_W-1:0]   page;
    } ffpe_result_t;

endpackage

@@ design/ffpe_ctrl.sv @@
`include "assert_macros.svh"

module ffpe_ctrl #(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_BITS   = 40
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_op,
    input  logic [ffpe_pkg::PAGE_FIELD_W-1:0]     in_base,
    input  logic [ffpe_pkg::PAGE_FIELD_W-1:0]     in_count,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output ffpe_pkg::ffpe_result_t                res
);
    import ffpe_pkg::*;

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int PW    = PAGE_BITS;
    localparam int EW    = 2 * PAGE_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_SHRINK = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [IDX_W-1:0]        chk_reg, chk_next;
    logic                    op_reg, op_next;
    logic [PW-1:0]           base_reg, base_next;
    logic [PW-1:0]           count_reg, count_next;
    logic [PW-1:0]           start_reg, start_next;
    logic [PW-1:0]           rem_reg, rem_next;
    status_t                 status_reg, status_next;
    logic [PAGE_FIELD_W-1:0] page_reg, page_next;

    logic [EW-1:0]           ext_mem [MAX_EXTENTS];
    logic [EW-1:0]           rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [EW-1:0]           wr_data;

    logic [PW-1:0]           rd_len;
    logic [PW-1:0]           rd_start;
    logic [PW:0]             diff;
    logic                    fits;
    logic                    exact;
    logic [CNT_W-1:0]        chk_plus1;
    logic [CNT_W-1:0]        chk_plus2;

    // Entries are {start, length}; the read port is registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ext_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= ext_mem[rd_addr];
    end

    assign rd_len    = rd_data_reg[PW-1:0];
    assign rd_start  = rd_data_reg[EW-1:PW];
    assign diff      = {1'b0, rd_len} - {1'b0, count_reg};
    assign fits      = !diff[PW];
    assign exact     = fits && (diff[PW-1:0] == '0);
    assign chk_plus1 = CNT_W'(chk_reg) + 1'b1;
    assign chk_plus2 = chk_plus1 + 1'b1;

    always_comb begin
        state_next  = state_reg;
        used_next   = used_reg;
        chk_next    = chk_reg;
        op_next     = op_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        page_next   = page_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = chk_reg;
        wr_data     = {start_reg, rem_reg};
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next    = in_op;
                    base_next  = PW'(in_base);
                    count_next = PW'(in_count);
                    chk_next   = '0;
                    state_next = S_START;
                end
            end
            S_START: begin
                page_next = '0;
                if (op_reg) begin
                    if (used_reg == CNT_W'(MAX_EXTENTS)) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        wr_addr     = IDX_W'(used_reg);
                        wr_data     = {base_reg, count_reg};
                        used_next   = used_reg + 1'b1;
                        status_next = ST_OK;
                    end
                    state_next = S_DONE;
                end else if (used_reg == '0) begin
                    status_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end else begin
                    rd_addr    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (fits) begin
                    start_next  = rd_start;
                    rem_next    = diff[PW-1:0];
                    status_next = ST_OK;
                    if (exact) begin
                        page_next = PAGE_FIELD_W'(rd_start);
                        if (chk_plus1 == used_reg) begin
                            used_next  = used_reg - 1'b1;
                            state_next = S_DONE;
                        end else begin
                            rd_addr    = IDX_W'(chk_plus1);
                            state_next = S_SHIFT;
                        end
                    end else begin
                        state_next = S_SHRINK;
                    end
                end else if (chk_plus1 == used_reg) begin
                    status_next = ST_NO_FIT;
                    page_next   = '0;
                    state_next  = S_DONE;
                end else begin
                    rd_addr  = IDX_W'(chk_plus1);
                    chk_next = IDX_W'(chk_plus1);
                end
            end
            S_SHRINK: begin
                wr_en      = 1'b1;
                page_next  = PAGE_FIELD_W'(start_reg + rem_reg);
                state_next = S_DONE;
            end
            S_SHIFT: begin
                // The word read last cycle is the entry one place further down.
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                if (chk_plus2 == used_reg) begin
                    used_next  = used_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    rd_addr  = IDX_W'(chk_plus2);
                    chk_next = IDX_W'(chk_plus1);
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_reg    <= chk_next;
        op_reg     <= op_next;
        base_reg   <= base_next;
        count_reg  <= count_next;
        start_reg  <= start_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        page_reg   <= page_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.page   = page_reg;

    `ASSERT_HOLDS(a_used_bound, aclk, aresetn, used_reg <= CNT_W'(MAX_EXTENTS), "extent count overflow")
    `ASSERT_NEXT(a_idle_used, aclk, aresetn, state_reg == S_IDLE, used_reg == $past(used_reg), "extent count moved while idle")
    `ASSERT_HOLDS(a_scan_index, aclk, aresetn, (state_reg != S_SCAN) || (CNT_W'(chk_reg) < used_reg), "scan beyond table tail")
    `ASSERT_HOLDS(a_shift_index, aclk, aresetn, (state_reg != S_SHIFT) || (chk_plus1 < used_reg), "compaction beyond table tail")

endmodule

@@ design/ffpe_out_buf.sv @@
module ffpe_out_buf (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ffpe_pkg::ffpe_result_t                in_res,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ffpe_pkg::PAGE_FIELD_W-1:0]     m_tdata,
    output logic [1:0]                            m_tuser
);
    import ffpe_pkg::*;

    logic         valid_reg;
    ffpe_result_t data_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.page;
    assign m_tuser  = data_reg.status;

endmodule

@@ design/first_fit_page_extent_allocator.sv @@
// Channel | Direction | tdata (low bit up)             | tuser
// s_      | in        | base_page[39:0], page_count    | opcode (0 allocate, 1 release)
// m_      | out       | result_page[39:0]              | status (0 ok, 1 no fit, 2 full)
//
// A release appends the freed extent to the table, or reports it full, before the result word.
// An allocation scans the extents in order up to the first one that fits, reporting no fit
// if none does; it then writes back a shrunk extent, or moves each later extent up one place
// when an exact fit removes an entry.
// These steps follow from the extent memory, with one read and one write a cycle.
// aresetn is synchronous and empties the table; the memory itself is not cleared.
// The next word is accepted while a result is still held in the output register.
module first_fit_page_extent_allocator #(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_BITS   = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // base_page[39:0], page_count[79:40]
    input  logic [0:0]   s_tuser,   // opcode[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // result_page[39:0]
    output logic [1:0]   m_tuser    // status[1:0]
);
    import ffpe_pkg::*;

    logic         res_valid;
    logic         res_ready;
    ffpe_result_t res;

    ffpe_ctrl #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .PAGE_BITS   (PAGE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_base   (s_tdata[39:0]),
        .in_count  (s_tdata[79:40]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ffpe_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
